// ===== rtl/wscs_pkg.sv =====
// shared widths, register indexes and reset values of the windowed step count sampler
`default_nettype none

package wscs_pkg;

	localparam int TIME_W  = 40;
	localparam int END_W   = TIME_W + 1;
	localparam int TZ_W    = 18;
	localparam int CNT_W   = 32;
	localparam int WIN_W   = 17;
	localparam int STEPS_W = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;

	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 80;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_SECONDS = 2'd0,
		REG_MAX_STEPS      = 2'd1,
		REG_TIME_LIMIT     = 2'd2,
		REG_UNUSED         = 2'd3
	} cfg_reg_t;

	localparam logic [WIN_W-1:0]   WINDOW_SECONDS_RST = WIN_W'(300);
	localparam logic [STEPS_W-1:0] MAX_STEPS_RST      = STEPS_W'(100000);
	localparam logic [TIME_W-1:0]  TIME_LIMIT_RST     = TIME_W'(64'd4102444800);

endpackage

`default_nettype wire

// ===== rtl/windowed_step_count_sampler_unit.sv =====
// windowed step count sampler: turns cumulative counter ticks into per-window step records
//
// Every accepted tick yields exactly one result transaction. A tick is registered at the
// input, then one pass of compare and subtract logic against the window state produces the
// result register, so a tick can be accepted in every cycle unless both registers are full
// and m_tready is low. The result register is held while m_tready is low, and the input
// stage keeps taking ticks until both registers are full. Configuration writes are always
// accepted and must be made only while no tick is in flight.
`default_nettype none

module windowed_step_count_sampler_unit
	import wscs_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration write channel
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	// tick input
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [IN_DATA_W-1:0]    s_tdata,  // now_time, tz_offset, step_counter, zeros
	input  wire logic [0:0]              s_tuser,  // count_ready
	// record output
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [OUT_DATA_W-1:0]        m_tdata,  // stamp_time, step_total, record_tz, zeros
	output logic [1:0]                   m_tuser   // emit, sensor_seen
);

	logic [WIN_W-1:0]   window_seconds_q;
	logic [STEPS_W-1:0] max_steps_q;
	logic [TIME_W-1:0]  time_limit_q;

	logic [END_W-1:0]   window_end_q;
	logic [CNT_W-1:0]   window_base_q;
	logic               sensor_answered_q;

	logic               valid_s1;
	logic [TIME_W-1:0]  now_s1;
	logic [TZ_W-1:0]    tz_s1;
	logic               ready_s1;
	logic [CNT_W-1:0]   cum_s1;

	logic               out_valid_q;
	logic               emit_q;
	logic [TIME_W-1:0]  stamp_q;
	logic [STEPS_W-1:0] total_q;
	logic [TZ_W-1:0]    tz_q;
	logic               seen_q;

	logic               out_adv;
	logic               s1_adv;

	logic [END_W-1:0]   win_ext;
	logic [END_W-1:0]   now_ext;
	logic               fresh;
	logic               still_open;
	logic [END_W-1:0]   lag;
	logic               watched;
	logic [END_W-1:0]   stamp;
	logic [CNT_W-1:0]   delta;
	logic               emit;
	logic [END_W-1:0]   next_end;

	assign cfg_ready = 1'b1;

	assign out_adv  = !out_valid_q || m_tready;
	assign s1_adv   = valid_s1 && out_adv;
	assign s_tready = !valid_s1 || out_adv;

	always_comb begin
		win_ext    = {{(END_W-WIN_W){1'b0}}, window_seconds_q};
		now_ext    = {1'b0, now_s1};
		fresh      = (window_end_q == '0) ||
			((window_end_q > win_ext) && (now_ext < (window_end_q - win_ext)));
		still_open = now_ext < window_end_q;
		lag        = now_ext - window_end_q;
		watched    = lag < win_ext;
		stamp      = watched ? window_end_q : now_ext;
		delta      = cum_s1 - window_base_q;
		emit       = ready_s1 && !fresh && !still_open && (cum_s1 > window_base_q) &&
			(delta <= {{(CNT_W-STEPS_W){1'b0}}, max_steps_q}) &&
			(stamp != '0) && (stamp < {1'b0, time_limit_q});
		next_end   = (watched && !fresh) ? (window_end_q + win_ext) : (now_ext + win_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_seconds_q <= WINDOW_SECONDS_RST;
			max_steps_q      <= MAX_STEPS_RST;
			time_limit_q     <= TIME_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_SECONDS: window_seconds_q <= cfg_data[WIN_W-1:0];
				REG_MAX_STEPS:      max_steps_q      <= cfg_data[STEPS_W-1:0];
				REG_TIME_LIMIT:     time_limit_q     <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_s1   <= s_tdata[TIME_W-1:0];
			tz_s1    <= s_tdata[TIME_W+TZ_W-1:TIME_W];
			cum_s1   <= s_tdata[TIME_W+TZ_W+CNT_W-1:TIME_W+TZ_W];
			ready_s1 <= s_tuser[0];
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_end_q      <= '0;
			window_base_q     <= '0;
			sensor_answered_q <= 1'b0;
		end else if (s1_adv && ready_s1) begin
			sensor_answered_q <= 1'b1;
			if (fresh || !still_open) begin
				window_end_q  <= next_end;
				window_base_q <= cum_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			emit_q  <= emit;
			stamp_q <= emit ? stamp[TIME_W-1:0] : '0;
			total_q <= emit ? delta[STEPS_W-1:0] : '0;
			tz_q    <= emit ? tz_s1 : '0;
			seen_q  <= sensor_answered_q || ready_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-TIME_W-STEPS_W-TZ_W){1'b0}}, tz_q, total_q, stamp_q};
	assign m_tuser  = {seen_q, emit_q};

	a_emit_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && emit_q) |-> (total_q != '0 && stamp_q != '0 && seen_q))
		else $error("record emitted without steps, stamp or sensor");

	a_quiet_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !emit_q) |-> (total_q == '0 && stamp_q == '0 && tz_q == '0))
		else $error("non-record result carries data");

	a_sensor_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sensor_answered_q |=> sensor_answered_q)
		else $error("sensor answered flag cleared");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_adv) |=> (valid_s1 && $stable(now_s1) && $stable(cum_s1)))
		else $error("input stage lost a tick while stalled");

	a_state_only_on_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_adv && ready_s1) |=> ($stable(window_end_q) && $stable(window_base_q)))
		else $error("window state changed without a ready tick");

endmodule

`default_nettype wire

// ===== bench/windowed_step_count_sampler_unit_test.sv =====
// self-checking bench for the windowed step count sampler: directed cases and random ticks
`default_nettype none

module windowed_step_count_sampler_unit_test
	import wscs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_PCT = 12;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [63:0] MASK41 = (64'd1 << END_W) - 64'd1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic                emit;
		logic [TIME_W-1:0]   stamp;
		logic [STEPS_W-1:0]  total;
		logic [TZ_W-1:0]     tz;
		logic                seen;
	} step_record_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;

	// bench copy of the registers and window state
	logic [63:0] win_len = 64'd300;
	logic [63:0] step_limit = 64'd100000;
	logic [63:0] stamp_limit = 64'd4102444800;
	logic [63:0] win_end = '0;
	logic [31:0] win_base = '0;
	bit sensor_heard = 1'b0;

	step_record_t pending_records[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;

	windowed_step_count_sampler_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic step_record_t sample_window(logic [TIME_W-1:0] now, logic [TZ_W-1:0] tz,
			bit ready, logic [CNT_W-1:0] cnt);
		step_record_t rec;
		logic [63:0] now64;
		logic [63:0] stamp;
		logic [63:0] delta;
		bit watched;
		bit keep;
		rec = '0;
		now64 = 64'(now);
		if (!ready) begin
			rec.seen = sensor_heard;
			return rec;
		end
		sensor_heard = 1'b1;
		rec.seen = 1'b1;
		if (win_end == 0 || (win_end > win_len && now64 < win_end - win_len)) begin
			win_end = (now64 + win_len) & MASK41;
			win_base = cnt;
			return rec;
		end
		if (now64 < win_end)
			return rec;
		watched = (now64 - win_end) < win_len;
		stamp = watched ? win_end : now64;
		keep = 1'b0;
		delta = '0;
		if (cnt > win_base) begin
			delta = 64'(cnt) - 64'(win_base);
			keep = delta <= step_limit && stamp > 0 && stamp < stamp_limit;
		end
		win_end = (watched ? win_end + win_len : now64 + win_len) & MASK41;
		win_base = cnt;
		if (keep) begin
			rec.emit = 1'b1;
			rec.stamp = stamp[TIME_W-1:0];
			rec.total = delta[STEPS_W-1:0];
			rec.tz = tz;
		end
		return rec;
	endfunction

	task automatic send_tick(logic [63:0] now, int tz, bit ready, logic [63:0] cnt);
		logic [TZ_W-1:0] tz_bits;
		tz_bits = TZ_W'(tz);
		@(negedge clk);
		if (!calm && $urandom_range(99) < STALL_PCT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata = {6'd0, cnt[CNT_W-1:0], tz_bits, now[TIME_W-1:0]};
		s_tuser = ready;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_records.push_back(sample_window(now[TIME_W-1:0], tz_bits, ready, cnt[CNT_W-1:0]));
	endtask

	task automatic drain(int extra);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_records.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		drain(4);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WINDOW_SECONDS: win_len = 64'(value[WIN_W-1:0]);
			REG_MAX_STEPS: step_limit = 64'(value[STEPS_W-1:0]);
			REG_TIME_LIMIT: stamp_limit = 64'(value[TIME_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// reset values: open, hold, watched, unwatched, drops, backwards clock, stamp limit
	task automatic test_default_windows();
		send_tick(1000, 0, 0, 77);
		send_tick(1000, 3600, 1, 50);
		send_tick(1100, 3600, 1, 9999);
		send_tick(1300, -86400, 1, 150);
		send_tick(1650, 86400, 1, 160);
		send_tick(3000, -1, 1, 200);
		send_tick(3300, 0, 1, 10);
		send_tick(3600, 0, 1, 10);
		send_tick(3900, 0, 1, 100011);
		send_tick(4200, 0, 1, 200011);
		send_tick(100, 0, 1, 5);
		send_tick(400, 0, 1, 64'hFFFF_FFFF);
		send_tick(64'(TIME_MAX), 0, 1, 5);
		send_tick(0, 0, 1, 0);
		send_tick(64'd4102444799, 1, 1, 3);
		send_tick(64'd4102445099, 1, 1, 4);
	endtask

	// register extremes, masking, zero window, zero max_steps, grown window, unused index
	task automatic test_register_extremes();
		write_reg(REG_WINDOW_SECONDS, 40'd1);
		write_reg(REG_MAX_STEPS, 40'd1);
		write_reg(REG_TIME_LIMIT, TIME_MAX);
		send_tick(10, 0, 1, 0);
		send_tick(11, 0, 1, 1);
		send_tick(12, 0, 1, 3);
		write_reg(REG_MAX_STEPS, 40'hFF_FFF0_0000);
		send_tick(13, 0, 1, 4);
		write_reg(REG_TIME_LIMIT, 40'd1);
		write_reg(REG_MAX_STEPS, 40'hAB_000F_4240);
		send_tick(14, 0, 1, 1000004);
		write_reg(REG_TIME_LIMIT, TIME_MAX);
		write_reg(REG_WINDOW_SECONDS, 40'hFF_FFFF_5180);
		send_tick(15, 0, 1, 1000005);
		write_reg(REG_WINDOW_SECONDS, 40'd0);
		send_tick(100000, 0, 1, 1000010);
		send_tick(100000, 0, 1, 1000011);
		send_tick(0, 0, 1, 1000012);
		send_tick(5, 0, 1, 1000013);
		write_reg(REG_WINDOW_SECONDS, 40'd10);
		send_tick(50, 0, 1, 1000020);
		write_reg(REG_WINDOW_SECONDS, 40'd100);
		send_tick(0, 0, 1, 1000022);
		send_tick(70, 0, 1, 1000025);
		write_reg(REG_UNUSED, 40'({$urandom, $urandom}));
	endtask

	task automatic test_random_ticks();
		int phase_len[7] = '{250, 250, 250, 250, 250, 110, 60};
		logic [63:0] now_t;
		logic [63:0] cnt;
		logic [63:0] span;
		logic [63:0] w;
		int pick;
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin
					write_reg(REG_WINDOW_SECONDS, 40'($urandom_range(60, 600)));
					write_reg(REG_MAX_STEPS, 40'd100000);
					write_reg(REG_TIME_LIMIT, 40'd4102444800);
				end
				1: begin
					write_reg(REG_WINDOW_SECONDS, 40'd1);
					write_reg(REG_MAX_STEPS, 40'($urandom_range(1, 4000)));
					write_reg(REG_TIME_LIMIT, TIME_MAX);
				end
				2: begin
					write_reg(REG_WINDOW_SECONDS, 40'($urandom_range(1, 2000)));
					write_reg(REG_MAX_STEPS, 40'd1000000);
					write_reg(REG_TIME_LIMIT, {8'($urandom_range(1, 255)), 32'($urandom)});
				end
				3: begin
					write_reg(REG_WINDOW_SECONDS, 40'd86400);
					write_reg(REG_TIME_LIMIT, 40'd4102444800);
				end
				4: begin
					write_reg(REG_WINDOW_SECONDS, 40'($urandom_range(1, 50)));
					write_reg(REG_MAX_STEPS, 40'($urandom_range(1, 300)));
					write_reg(REG_TIME_LIMIT, TIME_MAX);
				end
				5: begin
					write_reg(REG_WINDOW_SECONDS, 40'd0);
					write_reg(REG_MAX_STEPS, 40'd1000000);
				end
				default: begin
					write_reg(REG_WINDOW_SECONDS, 40'($urandom_range(1, 600)));
					write_reg(REG_MAX_STEPS, 40'd0);
					write_reg(REG_TIME_LIMIT, 40'd1);
				end
			endcase
			calm = (p == 2);
			w = (win_len == 0) ? 64'd5 : win_len;
			span = step_limit + step_limit / 8 + 1;
			if (span > 4000)
				span = 4000;
			now_t = 64'($urandom_range(1, 32'hF000_0000));
			cnt = 64'($urandom);
			for (int i = 0; i < phase_len[p]; i++) begin
				pick = $urandom_range(99);
				if (pick < 82) begin
					now_t += ($urandom_range(99) < 80) ? 64'($urandom_range(0, 32'(w)))
						: 64'($urandom_range(0, 32'(4 * w)));
					cnt = ($urandom_range(99) < 92) ? cnt + 64'($urandom_range(0, 32'(span)))
						: 64'($urandom);
					send_tick(now_t, $urandom_range(0, 172800) - 86400,
						$urandom_range(19) != 0, cnt);
				end else if (pick < 88) begin
					send_tick({$urandom, $urandom}, $urandom_range(0, 172800) - 86400,
						1'($urandom_range(1)), 64'($urandom));
				end else if (pick < 94) begin
					now_t = (now_t > 4 * w) ? now_t - 64'($urandom_range(0, 32'(4 * w))) : 64'd0;
					send_tick(now_t, $urandom_range(0, 172800) - 86400, 1'b1, cnt);
				end else begin
					cnt = 64'($urandom_range(0, 100));
					send_tick(now_t, $urandom_range(0, 172800) - 86400, 1'b1, cnt);
				end
			end
		end
		calm = 1'b0;
	endtask

	always @(negedge clk)
		m_tready = calm ? 1'b1 : ($urandom_range(99) >= STALL_PCT);

	always @(posedge clk) begin
		step_record_t got;
		step_record_t want;
		if (m_tvalid && m_tready) begin
			got = '{emit: m_tuser[0], stamp: m_tdata[39:0], total: m_tdata[59:40],
				tz: m_tdata[77:60], seen: m_tuser[1]};
			if (pending_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected record: emit %0b stamp %0d total %0d tz %0d seen %0b",
						got.emit, got.stamp, got.total, $signed(got.tz), got.seen);
			end else begin
				want = pending_records.pop_front();
				if (got.emit !== want.emit || got.stamp !== want.stamp
						|| got.total !== want.total || got.tz !== want.tz
						|| got.seen !== want.seen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("record mismatch: expected emit %0b stamp %0d total %0d",
							want.emit, want.stamp, want.total,
							" tz %0d seen %0b,", $signed(want.tz), want.seen,
							" got emit %0b stamp %0d total %0d tz %0d seen %0b",
							got.emit, got.stamp, got.total, $signed(got.tz), got.seen);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("windowed_step_count_sampler_unit_test: errors");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_default_windows();
		test_register_extremes();
		test_random_ticks();
		drain(10);
		if (mismatches == 0)
			$display("windowed_step_count_sampler_unit_test: clean");
		else
			$display("windowed_step_count_sampler_unit_test: errors");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/wscs_pkg.sv
rtl/windowed_step_count_sampler_unit.sv
bench/windowed_step_count_sampler_unit_test.sv
